>>> rtl/dsi_pkg.sv
package dsi_pkg;

	// saturation limit of the character counter
	localparam longint unsigned COUNT_LIMIT = 65535;
	localparam logic [15:0] CNT_MAX = (COUNT_LIMIT < 65535) ? 16'(COUNT_LIMIT) : 16'hFFFF;

	// magnitude bounds
	localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAG_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAG_LIM = MAG_MAX / 64'd10;

	// character codes
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// word kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [2:0] {
		PH_START  = 3'b001,
		PH_SIGN   = 3'b010,
		PH_DIGITS = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_SIGN_ONLY = 3'd2,
		ST_NON_DIGIT = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	// parser state carried from word to word
	typedef struct packed {
		logic [63:0] mag;
		logic        neg;
		phase_t      phase;
		logic [15:0] cnt;
		status_t     err;
		logic [15:0] eidx;
		logic        pend;
	} dsi_state_t;

	// result of one string
	typedef struct packed {
		logic [63:0] value;
		status_t     status;
		logic [15:0] epos;
		logic [15:0] len;
	} dsi_result_t;

	localparam dsi_state_t STATE_RESET = '{
		mag:   64'd0,
		neg:   1'b0,
		phase: PH_START,
		cnt:   16'd0,
		err:   ST_OK,
		eidx:  16'd0,
		pend:  1'b0
	};

endpackage

>>> rtl/dsi_step.sv
module dsi_step import dsi_pkg::*; (
	input  dsi_state_t  st,
	input  logic        kind,
	input  logic [7:0]  character,
	output dsi_state_t  nxt,
	output dsi_result_t res
);

	logic        digit;
	logic [63:0] d;
	logic [63:0] mag10;
	logic [63:0] sum;

	// digit decode and multiply by ten as shift and add
	assign digit = (character >= CH_ZERO) && (character <= CH_NINE);
	assign d     = digit ? {60'd0, 4'(character - CH_ZERO)} : 64'd0;
	assign mag10 = {st.mag[60:0], 3'b000} + {st.mag[62:0], 1'b0};
	assign sum   = mag10 + d;

	// next state and end-of-string result
	always_comb begin
		nxt        = st;
		res.value  = 64'd0;
		res.status = ST_OK;
		res.epos   = 16'd0;
		res.len    = st.cnt;
		if (kind == KIND_END) begin
			if (st.err != ST_OK) begin
				res.status = st.err;
				res.epos   = st.eidx;
			end else if (st.phase == PH_START) begin
				res.status = ST_EMPTY;
			end else if (st.phase == PH_SIGN) begin
				res.status = ST_SIGN_ONLY;
			end else begin
				res.value = st.neg ? (64'd0 - st.mag) : st.mag;
			end
			nxt = STATE_RESET;
		end else begin
			if (st.cnt < CNT_MAX) begin
				nxt.cnt = st.cnt + 16'd1;
			end
			if (st.err != ST_OK) begin
				// ignore until end
			end else if (st.pend) begin
				// anything after the most negative value
				nxt.err  = ST_OVERFLOW;
				nxt.eidx = st.cnt;
				nxt.pend = 1'b0;
			end else if (st.phase == PH_START &&
				(character == CH_MINUS || character == CH_PLUS)) begin
				nxt.neg   = (character == CH_MINUS);
				nxt.phase = PH_SIGN;
			end else if (!digit) begin
				nxt.err  = ST_NON_DIGIT;
				nxt.eidx = st.cnt;
			end else if (st.phase != PH_DIGITS) begin
				nxt.mag   = d;
				nxt.phase = PH_DIGITS;
			end else if (st.mag > MAG_LIM) begin
				nxt.err  = ST_OVERFLOW;
				nxt.eidx = st.cnt;
			end else if (sum[63]) begin
				if (st.neg && sum == MAG_MIN) begin
					nxt.mag  = MAG_MIN;
					nxt.pend = 1'b1;
				end else begin
					nxt.err  = ST_OVERFLOW;
					nxt.eidx = st.cnt;
				end
			end else begin
				nxt.mag = sum;
			end
		end
	end

endmodule

>>> rtl/decimal_string_to_int64_top.sv
// a string's result is registered and valid in the cycle after its end word is accepted
// throughput: one word per cycle, characters and end words alike, while no result waits untaken
// the rate is set by the combinational multiply-by-ten and range compares
// reset (arst_n low, asynchronous) clears the parser state and the result valid
module decimal_string_to_int64_top import dsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [7:0]         character,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] value,
	output logic [2:0]         status,
	output logic [15:0]        error_position,
	output logic [15:0]        string_length
);

	dsi_state_t  state_q;
	dsi_state_t  state_nxt;
	dsi_result_t res;
	dsi_result_t res_q;
	logic        out_valid_q;
	logic        in_acc;

	// a word is taken unless a result is waiting and not being taken
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	dsi_step u_step (
		.st        (state_q),
		.kind      (kind),
		.character (character),
		.nxt       (state_nxt),
		.res       (res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && kind == KIND_END) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_END) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = signed'(res_q.value);
	assign status         = res_q.status;
	assign error_position = res_q.epos;
	assign string_length  = res_q.len;

endmodule

>>> tb/tb_decimal_string_to_int64_top.sv
`timescale 1ns / 1ps

module tb_decimal_string_to_int64_top;
	import dsi_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned REPORT_MAX = 10;

	// receiver stall modes
	localparam int unsigned RX_FREE = 0;
	localparam int unsigned RX_COIN = 1;
	localparam int unsigned RX_SLOW = 2;

	typedef struct {
		logic       kind;
		logic [7:0] ch;
	} word_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               kind;
	logic [7:0]         character;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] value;
	logic [2:0]         status;
	logic [15:0]        error_position;
	logic [15:0]        string_length;

	// words waiting to be sent and results waiting to come back
	word_t       word_q[$];
	dsi_result_t parsed_q[$];

	// parser shadow state
	logic [63:0] acc_mag;
	logic        acc_neg;
	phase_t      acc_phase;
	logic [15:0] acc_cnt;
	status_t     acc_err;
	logic [15:0] acc_eidx;
	logic        acc_pend;

	int unsigned mismatches;
	int unsigned cycles;
	bit          word_taken;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned rx_mode;
	int unsigned rx_left;
	word_t       next_word;

	decimal_string_to_int64_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.character      (character),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.status         (status),
		.error_position (error_position),
		.string_length  (string_length)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic clear_parser();
		acc_mag   = '0;
		acc_neg   = 1'b0;
		acc_phase = PH_START;
		acc_cnt   = '0;
		acc_err   = ST_OK;
		acc_eidx  = '0;
		acc_pend  = 1'b0;
	endtask

	task automatic raise_error(input status_t code, input logic [15:0] pos);
		acc_err  = code;
		acc_eidx = pos;
		acc_pend = 1'b0;
	endtask

	// advance the shadow parser by one word, queue a result on end words
	task automatic parse_word(input logic k, input logic [7:0] c);
		logic [15:0] pos;
		logic        is_digit;
		logic [63:0] d;
		logic [63:0] times_ten;
		dsi_result_t res;
		pos = acc_cnt;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? 64'(c - CH_ZERO) : 64'd0;
		if (k == KIND_END) begin
			res.value = '0;
			res.epos  = '0;
			res.len   = acc_cnt;
			if (acc_err != ST_OK) begin
				res.status = acc_err;
				res.epos   = acc_eidx;
			end else if (acc_phase == PH_START) begin
				res.status = ST_EMPTY;
			end else if (acc_phase == PH_SIGN) begin
				res.status = ST_SIGN_ONLY;
			end else begin
				res.status = ST_OK;
				res.value  = acc_neg ? (64'd0 - acc_mag) : acc_mag;
			end
			parsed_q.push_back(res);
			clear_parser();
			return;
		end
		if (acc_cnt < CNT_MAX)
			acc_cnt = acc_cnt + 16'd1;
		if (acc_err != ST_OK)
			return;
		if (acc_pend) begin
			raise_error(ST_OVERFLOW, pos);
			return;
		end
		if (acc_phase == PH_START && (c == CH_MINUS || c == CH_PLUS)) begin
			acc_neg   = (c == CH_MINUS);
			acc_phase = PH_SIGN;
			return;
		end
		if (!is_digit) begin
			raise_error(ST_NON_DIGIT, pos);
			return;
		end
		if (acc_phase != PH_DIGITS) begin
			acc_mag   = d;
			acc_phase = PH_DIGITS;
			return;
		end
		if (acc_mag > MAG_MAX / 64'd10) begin
			raise_error(ST_OVERFLOW, pos);
			return;
		end
		times_ten = acc_mag * 64'd10;
		if (times_ten > MAG_MAX - d) begin
			if (acc_neg && (times_ten + d == MAG_MIN)) begin
				acc_mag  = MAG_MIN;
				acc_pend = 1'b1;
			end else begin
				raise_error(ST_OVERFLOW, pos);
			end
			return;
		end
		acc_mag = times_ten + d;
	endtask

	task automatic put_char(input logic [7:0] c);
		word_t w;
		w.kind = KIND_CHAR;
		w.ch   = c;
		word_q.push_back(w);
	endtask

	task automatic put_end();
		word_t w;
		w.kind = KIND_END;
		w.ch   = 8'($urandom_range(0, 255));
		word_q.push_back(w);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_sign();
		case ($urandom_range(0, 2))
			0: put_char(CH_MINUS);
			1: put_char(CH_PLUS);
			default: ;
		endcase
	endtask

	task automatic put_digits(input int unsigned n);
		repeat (n)
			put_char(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// magnitude near one of the range boundaries
	function automatic logic [63:0] boundary_mag();
		logic [63:0] m;
		case ($urandom_range(0, 5))
			0: m = MAG_MAX;
			1: m = MAG_MIN;
			2: m = MAG_MAX / 64'd10;
			3: m = (MAG_MAX / 64'd10) * 64'd10;
			4: m = 64'd9999999999999999999;
			default: m = 64'd1000000000000000000;
		endcase
		if ($urandom_range(0, 1))
			m = m + 64'($urandom_range(0, 3));
		else
			m = m - 64'($urandom_range(0, 3));
		return m;
	endfunction

	// one random string of some shape, end word included
	task automatic put_random_string();
		int unsigned n;
		int unsigned at;
		case ($urandom_range(0, 11))
			0: ;
			1: put_sign();
			2, 3, 4: begin
				put_sign();
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) put_char(CH_ZERO);
				put_digits($urandom_range(1, 19));
			end
			5, 6: begin
				put_sign();
				put_text($sformatf("%0d", boundary_mag()));
			end
			7: begin
				put_char(CH_MINUS);
				put_text($sformatf("%0d", MAG_MIN));
				repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)));
			end
			8: begin
				put_sign();
				put_digits($urandom_range(20, 26));
			end
			9: begin
				// number with one stray byte somewhere
				n = $urandom_range(1, 12);
				at = $urandom_range(0, n);
				put_sign();
				for (int i = 0; i <= n; i++) begin
					if (i == at)
						put_char(8'($urandom_range(0, 255)));
					else
						put_digits(1);
				end
			end
			10: begin
				repeat ($urandom_range(1, 3)) put_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
				put_digits($urandom_range(0, 4));
			end
			default: repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)));
		endcase
		put_end();
	endtask

	// driver: bursts of words with random gaps, inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			word_taken = 1'b0;
		end else if (in_valid && !word_taken) begin
			// hold the word until it is taken
		end else begin
			word_taken = 1'b0;
			if (gap_left != 0 || word_q.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				next_word = word_q.pop_front();
				kind      <= next_word.kind;
				character <= next_word.ch;
				in_valid  <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver stall pattern in randomly chosen modes
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_FREE, RX_SLOW);
			rx_left = $urandom_range(20, 80);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_FREE: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// monitor: predict on accepted words, check results in order
	always @(posedge clk) begin : monitor
		dsi_result_t exp;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_word(kind, character);
				word_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (parsed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result: value %0d status %0d pos %0d len %0d",
							value, status, error_position, string_length);
				end else begin
					exp = parsed_q.pop_front();
					if (value !== exp.value || status !== 3'(exp.status) ||
						error_position !== exp.epos || string_length !== exp.len) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"result mismatch: expected value %0d status %0d pos %0d ",
								"len %0d, got value %0d status %0d pos %0d len %0d"},
								$signed(exp.value), exp.status, exp.epos, exp.len,
								value, status, error_position, string_length);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned start_size;
		in_valid   = 1'b0;
		kind       = KIND_CHAR;
		character  = 8'd0;
		out_ready  = 1'b0;
		arst_n     = 1'b0;
		mismatches = 0;
		cycles     = 0;
		word_taken = 1'b0;
		burst_left = 1;
		gap_left   = 0;
		rx_mode    = RX_FREE;
		rx_left    = 0;
		clear_parser();

		// directed: empty, sign only, all-ones byte, sign after a digit, most negative value
		put_end();
		put_char(CH_PLUS);
		put_end();
		put_char(8'hFF);
		put_end();
		put_char(CH_ZERO + 8'd5);
		put_char(CH_MINUS);
		put_end();
		put_char(CH_MINUS);
		put_text($sformatf("%0d", MAG_MIN));
		put_end();

		// random strings
		start_size = word_q.size();
		while (word_q.size() - start_size < RANDOM_WORDS)
			put_random_string();

		put_digits(3);
		put_end();

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || in_valid)
			@(posedge clk);
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && parsed_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
